>>> sv/cfp_pkg.sv
// Package for the camera frame parser.
// Holds the frame byte codes, the field window span and the control struct.
// No dependencies.
`default_nettype none
package cfp_pkg;

    localparam logic [7:0] HEAD_ONE   = 8'h2C;
    localparam logic [7:0] HEAD_TWO   = 8'h12;
    localparam logic [7:0] END_MARK   = 8'h5B;

    // bytes that make up one result: ten fields plus the final byte
    localparam int unsigned FIELD_SPAN = 11;
    localparam int unsigned TAP_COUNT  = FIELD_SPAN - 1;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic hold;    // accepted byte goes into the frame store
        logic emit;    // accepted byte ends a frame long enough to report
        logic marker;  // frame ended on the terminator byte
    } ctrl_t;

endpackage : cfp_pkg
`default_nettype wire

>>> sv/cfp_cell.sv
// One byte cell of the frame shift line.
// Uses cfp_pkg for the byte type.
`default_nettype none
module cfp_cell
    import cfp_pkg::*;
(
    input  wire   aclk,
    input  wire   shift_en,
    input  byte_t d_in,
    output byte_t q
);

    byte_t q_reg;
    byte_t q_next;

    always_comb begin
        q_next = shift_en ? d_in : q_reg;
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule : cfp_cell
`default_nettype wire

>>> sv/cfp_ctrl.sv
// Frame phase and byte count tracking for the camera frame parser.
// Uses cfp_pkg for byte codes and the control struct.
`default_nettype none
module cfp_ctrl
    import cfp_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 16
) (
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   accept,
    input  byte_t rx_byte,
    output ctrl_t ctrl
);

    localparam int unsigned CW = $clog2(FRAME_MAX + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_inc;
    logic          is_mark;
    logic          at_end;

    assign count_inc = count_reg + CW'(1);
    assign is_mark   = (rx_byte == END_MARK);
    assign at_end    = (count_inc >= CW'(FRAME_MAX)) || is_mark;

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        ctrl.hold   = 1'b0;
        ctrl.emit   = 1'b0;
        ctrl.marker = is_mark;
        if (accept) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (rx_byte == HEAD_ONE) begin
                        ctrl.hold  = 1'b1;
                        count_next = count_inc;
                        phase_next = PH_HEAD;
                    end else begin
                        count_next = '0;
                    end
                end
                PH_HEAD: begin
                    if (rx_byte == HEAD_TWO) begin
                        ctrl.hold  = 1'b1;
                        count_next = count_inc;
                        phase_next = PH_BODY;
                    end else begin
                        count_next = '0;
                        phase_next = PH_IDLE;
                    end
                end
                PH_BODY: begin
                    // count stays below FRAME_MAX here, so the byte always fits
                    ctrl.hold  = 1'b1;
                    count_next = count_inc;
                    if (at_end) begin
                        phase_next = PH_DONE;
                        ctrl.emit  = (count_inc >= CW'(FIELD_SPAN));
                    end
                end
                default: begin
                    // swallow the byte after a frame end
                    count_next = '0;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule : cfp_ctrl
`default_nettype wire

>>> sv/camera_frame_parser_core.sv
// Camera frame parser: takes one serial byte per item and reports the ten
// field bytes of each frame. A frame opens with 0x2C 0x12 and closes on the
// terminator 0x5B or when FRAME_MAX bytes (header included) are held; the
// ten bytes just before the closing byte are given out as one result, and
// frames under 11 bytes give none. The byte after a frame end is dropped.
// The bytes move down a row of ten byte cells, and a result sits in an output
// register, so a byte is accepted every cycle unless a result is waiting and
// m_ready is low. A result appears in the cycle after its closing byte is
// accepted. Depends on cfp_pkg, cfp_cell, cfp_ctrl.
`default_nettype none
module camera_frame_parser_core
    import cfp_pkg::*;
#(
    parameter int unsigned FRAME_MAX = 16
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_rx_byte,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_pos_x,
    output logic [7:0] m_pos_y,
    output logic [7:0] m_box_width,
    output logic [7:0] m_box_height,
    output logic [7:0] m_quality,
    output logic [7:0] m_error_code,
    output logic [7:0] m_spare_one,
    output logic [7:0] m_spare_two,
    output logic [7:0] m_spare_three,
    output logic [7:0] m_spare_four,
    output logic       m_ended_by_marker
);

    logic  accept;
    ctrl_t ctrl;
    byte_t tap [TAP_COUNT];

    logic  m_valid_reg;
    logic  m_valid_next;
    byte_t field_reg [TAP_COUNT];
    logic  marker_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    cfp_ctrl #(
        .FRAME_MAX (FRAME_MAX)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .ctrl    (ctrl)
    );

    // tap[0] holds the newest stored byte, tap[TAP_COUNT-1] the oldest
    for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
        if (i == 0) begin : g_head
            cfp_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctrl.hold),
                .d_in     (s_rx_byte),
                .q        (tap[i])
            );
        end else begin : g_body
            cfp_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctrl.hold),
                .d_in     (tap[i-1]),
                .q        (tap[i])
            );
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // load the window of ten bytes before the closing byte
    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                field_reg[k] <= tap[TAP_COUNT-1-k];
            end
            marker_reg <= ctrl.marker;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pos_x           = field_reg[0];
    assign m_pos_y           = field_reg[1];
    assign m_box_width       = field_reg[2];
    assign m_box_height      = field_reg[3];
    assign m_quality         = field_reg[4];
    assign m_error_code      = field_reg[5];
    assign m_spare_one       = field_reg[6];
    assign m_spare_two       = field_reg[7];
    assign m_spare_three     = field_reg[8];
    assign m_spare_four      = field_reg[9];
    assign m_ended_by_marker = marker_reg;

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_rise_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted item");

    a_emit_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> accept && ctrl.hold)
        else $error("frame end reported without a stored byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pos_x) && $stable(m_spare_four)))
        else $error("waiting result was lost or overwritten");

endmodule : camera_frame_parser_core
`default_nettype wire
